@@ hdl/vibration_statistics_top_macros.svh @@
// ----------------------------------------------------------------------------
// vibration statistics assertion macros
// shared concurrent assertion forms, clocked on clk, disabled in reset
// ----------------------------------------------------------------------------
`ifndef VIBRATION_STATISTICS_TOP_MACROS_SVH
`define VIBRATION_STATISTICS_TOP_MACROS_SVH

// antecedent implies consequent in the same cycle
`define VSTAT_ASSERT_IMP(label, ante, cons, msg) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
    else $error(msg);

// antecedent implies consequent in the next cycle
`define VSTAT_ASSERT_NEXT(label, ante, cons, msg) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
    else $error(msg);

`endif

@@ hdl/vstat_pkg.sv @@
// ----------------------------------------------------------------------------
// vibration statistics package
// request and result types, shared divide/root unit control and constants
// ----------------------------------------------------------------------------
package vstat_pkg;

  localparam int SAMPLE_W = 16;
  localparam int RMS_W    = 24;
  localparam int REM_W    = 26;
  localparam int TRY_W    = REM_W + 1;
  localparam int FRAC_W   = 16;

  typedef struct packed {
    logic [SAMPLE_W-1:0] sample;
    logic                last;
  } vstat_in_t;

  typedef struct packed {
    logic [SAMPLE_W-1:0] mean;
    logic [RMS_W-1:0]    rms_q8;
    logic [SAMPLE_W-1:0] peak_max;
    logic [SAMPLE_W-1:0] peak_min;
    logic [SAMPLE_W-1:0] amplitude;
    logic [SAMPLE_W-1:0] crest_q8;
    logic                zero_rms;
  } vstat_out_t;

  typedef struct packed {
    logic start;
    logic sqrt_mode;
  } vstat_alu_ctl_t;

  typedef struct packed {
    logic busy;
    logic done;
  } vstat_alu_sts_t;

  typedef enum logic [5:0] {
    S_ACC   = 6'b000001,
    S_MEAN  = 6'b000010,
    S_SCALE = 6'b000100,
    S_ROOT  = 6'b001000,
    S_CREST = 6'b010000,
    S_EMIT  = 6'b100000
  } vstat_state_t;

endpackage

@@ hdl/vibration_statistics_top.sv @@
// ----------------------------------------------------------------------------
// vibration statistics top level
// buffer mean, rms, peaks, amplitude and crest factor over a sample stream
// ----------------------------------------------------------------------------
// in channel: one sample request per cycle (in_valid/in_stall); in_data.last
// closes the buffer. samples past MAX_SAMPLES in one buffer are dropped from
// the statistics, the last one still closes the buffer.
// out channel: one result request per buffer on out_valid/out_stall.
// while accumulating, a sample is taken every cycle. after a last sample the
// block stalls the in channel while one shared bit-serial compare-subtract
// unit works out the mean, sum_sq*65536/n, the root and the crest factor
// in turn, on dividends of DW = 48 + clog2(MAX_SAMPLES+1) bits.
// the result sits in an output register; a stalled result holds and the
// next buffer accumulates behind it. a finished result that still finds the
// previous one waiting is held until that one is taken.
// reset (rst_n low, synchronous) empties the buffer and drops any result.
// ----------------------------------------------------------------------------
module vibration_statistics_top import vstat_pkg::*; #(
  parameter int MAX_SAMPLES = 4096
) (
  input  logic       clk,
  input  logic       rst_n,
  input  logic       in_valid,
  output logic       in_stall,
  input  vstat_in_t  in_data,
  output logic       out_valid,
  input  logic       out_stall,
  output vstat_out_t out_data
);

  `include "vibration_statistics_top_macros.svh"

  localparam int CW = $clog2(MAX_SAMPLES + 1);
  localparam int SW = SAMPLE_W + CW;
  localparam int QW = 2 * SAMPLE_W + CW;
  localparam int DW = QW + FRAC_W;

  vstat_state_t state_r, state_nxt;

  logic [SW-1:0]         sum_r;
  logic [QW-1:0]         sq_r;
  logic [SAMPLE_W-1:0]   min_r;
  logic [SAMPLE_W-1:0]   max_r;
  logic [CW-1:0]         cnt_r;
  logic [2*SAMPLE_W-1:0] prod_r;
  logic                  prod_v_r;
  logic                  launch_r;
  logic [SAMPLE_W-1:0]   mean_r;
  logic [RMS_W-1:0]      rms_r;
  logic [SAMPLE_W-1:0]   crest_r;
  logic                  out_valid_r;
  vstat_out_t            out_r;

  logic           in_acc;
  logic           take;
  logic           emit;
  logic           step_done;
  vstat_alu_ctl_t alu_ctl;
  vstat_alu_sts_t alu_sts;
  logic [DW-1:0]  alu_num;
  logic [RMS_W-1:0] alu_den;
  logic [DW-1:0]  alu_quo;
  logic [RMS_W-1:0] alu_root;
  logic [SAMPLE_W-1:0] up;
  logic [SAMPLE_W-1:0] down;
  logic           zero;

  assign in_stall  = (state_r != S_ACC);
  assign in_acc    = in_valid && !in_stall;
  assign take      = in_acc && (cnt_r < CW'(MAX_SAMPLES));
  assign step_done = alu_sts.done;
  assign emit      = (state_r == S_EMIT) && (!out_valid_r || !out_stall);

  always_comb begin
    alu_ctl.start     = launch_r;
    alu_ctl.sqrt_mode = (state_r == S_ROOT);
    alu_den           = {{(RMS_W-CW){1'b0}}, cnt_r};
    case (state_r)
      S_MEAN:  alu_num = {{(DW-SW){1'b0}}, sum_r};
      S_SCALE: alu_num = {sq_r, {FRAC_W{1'b0}}};
      S_ROOT:  alu_num = {alu_quo[2*RMS_W-1:0], {(DW-2*RMS_W){1'b0}}};
      S_CREST: begin
        alu_num = {{(DW-SAMPLE_W-FRAC_W){1'b0}}, max_r, {FRAC_W{1'b0}}};
        alu_den = rms_r;
      end
      default: alu_num = '0;
    endcase
  end

  always_comb begin
    state_nxt = state_r;
    case (state_r)
      S_ACC:   if (in_acc && in_data.last) state_nxt = S_MEAN;
      S_MEAN:  if (step_done) state_nxt = S_SCALE;
      S_SCALE: if (step_done) state_nxt = S_ROOT;
      S_ROOT:  if (step_done) state_nxt = S_CREST;
      S_CREST: if (step_done) state_nxt = S_EMIT;
      S_EMIT:  if (emit) state_nxt = S_ACC;
      default: state_nxt = S_ACC;
    endcase
  end

  vstat_alu #(
    .DW (DW)
  ) u_alu (
    .clk   (clk),
    .rst_n (rst_n),
    .ctl   (alu_ctl),
    .num   (alu_num),
    .den   (alu_den),
    .sts   (alu_sts),
    .quo   (alu_quo),
    .root  (alu_root)
  );

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= S_ACC;
      launch_r    <= 1'b0;
      prod_v_r    <= 1'b0;
      sum_r       <= '0;
      sq_r        <= '0;
      min_r       <= '1;
      max_r       <= '0;
      cnt_r       <= '0;
      out_valid_r <= 1'b0;
    end else begin
      state_r  <= state_nxt;
      launch_r <= (state_nxt != state_r) && (state_nxt != S_EMIT) && (state_nxt != S_ACC);
      prod_v_r <= take;
      if (prod_v_r) begin
        sq_r <= sq_r + QW'(prod_r);
      end
      if (take) begin
        sum_r <= sum_r + SW'(in_data.sample);
        cnt_r <= cnt_r + 1'b1;
        if (in_data.sample < min_r) min_r <= in_data.sample;
        if (in_data.sample > max_r) max_r <= in_data.sample;
      end
      if (emit) begin
        sum_r       <= '0;
        sq_r        <= '0;
        min_r       <= '1;
        max_r       <= '0;
        cnt_r       <= '0;
        out_valid_r <= 1'b1;
      end else if (!out_stall) begin
        out_valid_r <= 1'b0;
      end
    end
  end

  always_comb begin
    up   = max_r - mean_r;
    down = mean_r - min_r;
    zero = (rms_r == '0);
  end

  always_ff @(posedge clk) begin
    if (take) begin
      prod_r <= (2*SAMPLE_W)'(in_data.sample) * (2*SAMPLE_W)'(in_data.sample);
    end
    if (step_done && state_r == S_MEAN) begin
      mean_r <= alu_quo[SAMPLE_W-1:0];
    end
    if (step_done && state_r == S_ROOT) begin
      rms_r <= alu_root;
    end
    if (step_done && state_r == S_CREST) begin
      crest_r <= (|alu_quo[DW-1:SAMPLE_W]) ? '1 : alu_quo[SAMPLE_W-1:0];
    end
    if (emit) begin
      out_r.mean      <= mean_r;
      out_r.rms_q8    <= rms_r;
      out_r.peak_max  <= max_r;
      out_r.peak_min  <= min_r;
      out_r.amplitude <= (up >= down) ? up : down;
      out_r.crest_q8  <= zero ? '0 : crest_r;
      out_r.zero_rms  <= zero;
    end
  end

  assign out_valid = out_valid_r;
  assign out_data  = out_r;

  `VSTAT_ASSERT_IMP(a_done_in_compute, alu_sts.done,
    state_r == S_MEAN || state_r == S_SCALE || state_r == S_ROOT || state_r == S_CREST,
    "divide/root unit finished outside a compute step")
  `VSTAT_ASSERT_IMP(a_count_bound, 1'b1, cnt_r <= CW'(MAX_SAMPLES),
    "sample count past buffer size")
  `VSTAT_ASSERT_IMP(a_zero_crest, out_valid_r && out_r.zero_rms, out_r.crest_q8 == '0,
    "zero rms with nonzero crest")
  `VSTAT_ASSERT_NEXT(a_launch_idle, launch_r, alu_sts.busy,
    "launch did not start the divide/root unit")

endmodule

@@ hdl/vstat_alu.sv @@
// ----------------------------------------------------------------------------
// vibration statistics divide and square root unit
// one compare-subtract stage, one quotient bit or one root bit per cycle
// ----------------------------------------------------------------------------
module vstat_alu import vstat_pkg::*; #(
  parameter int DW = 61
) (
  input  logic             clk,
  input  logic             rst_n,
  input  vstat_alu_ctl_t   ctl,
  input  logic [DW-1:0]    num,
  input  logic [RMS_W-1:0] den,
  output vstat_alu_sts_t   sts,
  output logic [DW-1:0]    quo,
  output logic [RMS_W-1:0] root
);

  localparam int STW = $clog2(DW);

  logic [DW-1:0]    sh_r;
  logic [REM_W-1:0] rem_r;
  logic [RMS_W-1:0] root_r;
  logic [RMS_W-1:0] den_r;
  logic [STW-1:0]   cnt_r;
  logic             busy_r;
  logic             done_r;
  logic             mode_r;

  logic [TRY_W-1:0] partial;
  logic [TRY_W-1:0] subtr;
  logic [TRY_W:0]   diff;
  logic             ge;
  logic [REM_W-1:0] rem_nxt;

  always_comb begin
    if (mode_r) begin
      partial = {rem_r[REM_W-2:0], sh_r[DW-1:DW-2]};
      subtr   = {1'b0, root_r, 2'b01};
    end else begin
      partial = {rem_r, sh_r[DW-1]};
      subtr   = {{(TRY_W-RMS_W){1'b0}}, den_r};
    end
    diff    = {1'b0, partial} - {1'b0, subtr};
    ge      = !diff[TRY_W];
    rem_nxt = ge ? diff[REM_W-1:0] : partial[REM_W-1:0];
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      busy_r <= 1'b0;
      done_r <= 1'b0;
      cnt_r  <= '0;
      mode_r <= 1'b0;
    end else begin
      done_r <= busy_r && (cnt_r == '0);
      if (ctl.start && !busy_r) begin
        busy_r <= 1'b1;
        mode_r <= ctl.sqrt_mode;
        cnt_r  <= ctl.sqrt_mode ? STW'(RMS_W - 1) : STW'(DW - 1);
      end else if (busy_r) begin
        cnt_r <= cnt_r - 1'b1;
        if (cnt_r == '0) begin
          busy_r <= 1'b0;
        end
      end
    end
  end

  always_ff @(posedge clk) begin
    if (ctl.start && !busy_r) begin
      sh_r   <= num;
      den_r  <= den;
      rem_r  <= '0;
      root_r <= '0;
    end else if (busy_r) begin
      rem_r <= rem_nxt;
      if (mode_r) begin
        sh_r   <= {sh_r[DW-3:0], 2'b00};
        root_r <= {root_r[RMS_W-2:0], ge};
      end else begin
        sh_r <= {sh_r[DW-2:0], ge};
      end
    end
  end

  assign sts.busy = busy_r;
  assign sts.done = done_r;
  assign quo      = sh_r;
  assign root     = root_r;

endmodule
